// ----- rtl/core/rgbtc_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbtc_pkg
// Shared constants and colour arithmetic for the RGBA to terminal colour core.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbtc_pkg;

    localparam int WORD_W  = 32;
    localparam int CODE_W  = 24;
    localparam int CHAN_W  = 8;
    localparam int MODE_W  = 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // colour modes
    localparam logic [MODE_W-1:0] MODE_TRUE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_P256  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_P16   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;
    localparam logic [MODE_W-1:0] MODE_RESET = MODE_P16;

    // register indexes
    localparam logic REG_OUT_MODE = 1'b0;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // floor(x / 255) for x up to 255*255, via x + x/256 + 1 then a shift
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // floor(c * 5 / 255) = floor(c / 51)
    function automatic logic [2:0] cube_level(input logic [CHAN_W-1:0] c);
        logic [2:0] lvl;
        if (c < 8'd51)       lvl = 3'd0;
        else if (c < 8'd102) lvl = 3'd1;
        else if (c < 8'd153) lvl = 3'd2;
        else if (c < 8'd204) lvl = 3'd3;
        else if (c < 8'd255) lvl = 3'd4;
        else                 lvl = 3'd5;
        return lvl;
    endfunction

    // grey ramp; (v - 8) / 10 as a multiply by 205 and a shift by 11
    function automatic logic [CHAN_W-1:0] grey_code(input logic [CHAN_W-1:0] v);
        logic [CHAN_W-1:0] d;
        logic [15:0]       p;
        logic [8:0]        s;
        logic [CHAN_W-1:0] code;
        d = v - 8'd8;
        p = {8'd0, d} * 16'd205;
        s = 9'd232 + {4'd0, p[15:11]};
        if (v < 8'd8)        code = 8'd16;
        else if (v > 8'd248) code = 8'd231;
        else if (s > 9'd255) code = 8'd255;
        else                 code = s[7:0];
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rgbtc_map.sv -----
// ----------------------------------------------------------------------------
// rgbtc_map
// Alpha blend onto black, then encode the colour in the selected mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbtc_map (
    input  wire logic [rgbtc_pkg::WORD_W-1:0] i_word,
    input  wire logic [rgbtc_pkg::MODE_W-1:0] i_mode,
    output logic      [rgbtc_pkg::CODE_W-1:0] o_code
);

    logic [rgbtc_pkg::CHAN_W-1:0] red_raw, grn_raw, blu_raw, alpha_raw;
    logic [rgbtc_pkg::CHAN_W-1:0] rc, gc, bc;
    logic [15:0]                  red_prod, grn_prod, blu_prod;
    logic [2:0]                   ri, gi, bi;
    logic [7:0]                   cube, c256;
    logic [3:0]                   c16;
    logic rl, gl, bl, rh, gh, bh, rm, gm, bm;

    assign red_raw   = i_word[31:24];
    assign grn_raw   = i_word[23:16];
    assign blu_raw   = i_word[15:8];
    assign alpha_raw = i_word[7:0];

    assign red_prod = {8'd0, red_raw} * {8'd0, alpha_raw};
    assign grn_prod = {8'd0, grn_raw} * {8'd0, alpha_raw};
    assign blu_prod = {8'd0, blu_raw} * {8'd0, alpha_raw};

    always_comb begin
        if (alpha_raw == rgbtc_pkg::CHAN_MAX) begin
            rc = red_raw;
            gc = grn_raw;
            bc = blu_raw;
        end else begin
            rc = rgbtc_pkg::div255(red_prod);
            gc = rgbtc_pkg::div255(grn_prod);
            bc = rgbtc_pkg::div255(blu_prod);
        end
    end

    // 256 palette: grey ramp or 6x6x6 cube
    assign ri   = rgbtc_pkg::cube_level(rc);
    assign gi   = rgbtc_pkg::cube_level(gc);
    assign bi   = rgbtc_pkg::cube_level(bc);
    assign cube = 8'd16 + 8'd36 * {5'd0, ri} + 8'd6 * {5'd0, gi} + {5'd0, bi};
    assign c256 = ((rc == gc) && (gc == bc)) ? rgbtc_pkg::grey_code(rc) : cube;

    // 16 palette: first matching test wins
    assign rl = rc < 8'd64;
    assign gl = gc < 8'd64;
    assign bl = bc < 8'd64;
    assign rh = rc > 8'd192;
    assign gh = gc > 8'd192;
    assign bh = bc > 8'd192;
    assign rm = rc < 8'd128;
    assign gm = gc < 8'd128;
    assign bm = bc < 8'd128;

    always_comb begin
        if (rl && gl && bl)      c16 = 4'd0;
        else if (rh && gl && bl) c16 = 4'd1;
        else if (rl && gh && bl) c16 = 4'd2;
        else if (rh && gh && bl) c16 = 4'd3;
        else if (rl && gl && bh) c16 = 4'd4;
        else if (rh && gl && bh) c16 = 4'd5;
        else if (rl && gh && bh) c16 = 4'd6;
        else if (rh && gh && bh) c16 = 4'd7;
        else if ((rc > 8'd128) && (gc > 8'd128) && (bc > 8'd128)) c16 = 4'd8;
        else if (rh && gm && bm) c16 = 4'd9;
        else if (rm && gh && bm) c16 = 4'd10;
        else if (rh && gh && bm) c16 = 4'd11;
        else if (rm && gm && bh) c16 = 4'd12;
        else if (rh && gm && bh) c16 = 4'd13;
        else if (rm && gh && bh) c16 = 4'd14;
        else                     c16 = 4'd15;
    end

    always_comb begin
        case (i_mode)
            rgbtc_pkg::MODE_TRUE: o_code = {rc, gc, bc};
            rgbtc_pkg::MODE_P256: o_code = {16'd0, c256};
            rgbtc_pkg::MODE_P16:  o_code = {20'd0, c16};
            rgbtc_pkg::MODE_NONE: o_code = '0;
            default:              o_code = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/rgba_to_terminal_color_core.sv -----
// ----------------------------------------------------------------------------
// rgba_to_terminal_color_core
// An accepted input beat passes through the input register, then the result register.
// Throughput: one beat per cycle while the output is not stalled; input register and result register are
// separated by the colour logic and advance together when the output is free.
// Reset (synchronous, active low) empties both stages; the output mode
// returns to the 16-colour mode.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_to_terminal_color_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream; tdata: [31:0] rgba_word
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [rgbtc_pkg::WORD_W-1:0] i_s_tdata,
    // output stream; tdata: [23:0] color_code
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [rgbtc_pkg::CODE_W-1:0] o_m_tdata,
    // configuration port
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [rgbtc_pkg::APB_AW-1:0] i_paddr,
    input  wire logic [rgbtc_pkg::APB_DW-1:0] i_pwdata,
    output logic [rgbtc_pkg::APB_DW-1:0] o_prdata,
    output logic             o_pready
);

    logic [rgbtc_pkg::MODE_W-1:0] r_mode;
    logic                         r_in_valid;
    logic [rgbtc_pkg::WORD_W-1:0] r_in_word;
    logic                         r_out_valid;
    logic [rgbtc_pkg::CODE_W-1:0] r_out_code;
    logic [rgbtc_pkg::CODE_W-1:0] n_out_code;
    logic                         adv;
    logic                         wr_en;

    // Register file: one register, byte offset within the word ignored.
    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite &&
                      (i_paddr[2] == rgbtc_pkg::REG_OUT_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= rgbtc_pkg::MODE_RESET;
        end else if (wr_en) begin
            r_mode <= i_pwdata[rgbtc_pkg::MODE_W-1:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (i_paddr[2] == rgbtc_pkg::REG_OUT_MODE) begin
            o_prdata[rgbtc_pkg::MODE_W-1:0] = r_mode;
        end
    end

    // Pipeline advances whenever the result register is empty or being taken.
    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_word <= i_s_tdata;
        end
    end

    rgbtc_map u_map (
        .i_word (r_in_word),
        .i_mode (r_mode),
        .o_code (n_out_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_out_code <= n_out_code;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_code;

endmodule

`default_nettype wire
